// ===== design/fixed_slot_free_list_allocator_macros.svh =====
// Assertion macros shared by the slot allocator modules.
`ifndef FIXED_SLOT_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIXED_SLOT_FREE_LIST_ALLOCATOR_MACROS_SVH
`ifndef SYNTH
`define FSLF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("slot allocator check failed");
`define FSLF_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("slot allocator forbidden condition seen");
`else
`define FSLF_ASSERT(lbl, clk, rst_n, prop)
`define FSLF_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== design/fslf_pkg.sv =====
// Types and constants for the fixed-slot free list allocator.
`timescale 1ns / 1ps
package fslf_pkg;

  localparam int SlotCountDef = 1024;
  localparam int SlotIdxW     = 10;
  localparam int ObjBytesW    = 13;
  localparam int OffsetW      = 22;
  localparam int StatusW      = 2;
  localparam int OpW          = 2;

  localparam logic [ObjBytesW-1:0] ObjBytesReset = 13'd16;

  localparam logic [OpW-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OpW-1:0] OP_RELEASE = 2'd1;
  localparam logic [OpW-1:0] OP_QUERY   = 2'd2;

  localparam logic [StatusW-1:0] STATUS_OK          = 2'd0;
  localparam logic [StatusW-1:0] STATUS_EXHAUSTED   = 2'd1;
  localparam logic [StatusW-1:0] STATUS_BAD_RELEASE = 2'd2;

  typedef struct packed {
    logic                valid;
    logic [SlotIdxW-1:0] granted;
    logic [StatusW-1:0]  status;
    logic                live;
  } res_t;

endpackage

// ===== design/fslf_mem.sv =====
// Single-port-write, registered-read memory holding the free mark and next link of each slot.
`timescale 1ns / 1ps
module fslf_mem #(
  parameter int Depth = 1024,
  parameter int AddrW = 10,
  parameter int DataW = 11
) (
  input  logic             clk_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/fslf_ctrl.sv =====
// Request sequencer: free list head, bump counter and read-modify-write of the slot memory.
`timescale 1ns / 1ps
`include "fixed_slot_free_list_allocator_macros.svh"
module fslf_ctrl #(
  parameter int SlotCount = fslf_pkg::SlotCountDef,
  localparam int SlotW = $clog2(SlotCount)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [fslf_pkg::OpW-1:0]      op_i,
  input  logic [fslf_pkg::SlotIdxW-1:0] slot_i,
  input  logic                          null_i,
  output logic                          mem_re_o,
  output logic [SlotW-1:0]              mem_raddr_o,
  input  logic [SlotW:0]                mem_rdata_i,
  output logic                          mem_we_o,
  output logic [SlotW-1:0]              mem_waddr_o,
  output logic [SlotW:0]                mem_wdata_o,
  output fslf_pkg::res_t                res_o
);
  import fslf_pkg::*;

  localparam int CntW = SlotW + 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e              state_q, state_d;
  logic [OpW-1:0]      op_q;
  logic [SlotIdxW-1:0] slot_q;
  logic                null_q;
  logic [SlotW-1:0]    head_q, head_d;
  logic                nonempty_q, nonempty_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                accept;
  logic [SlotW-1:0]    slot_idx;
  logic                rd_mark;
  logic [SlotW-1:0]    rd_link;
  logic                slot_live;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q == ST_EXEC);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      head_q     <= '0;
      nonempty_q <= 1'b0;
      count_q    <= '0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      nonempty_q <= nonempty_d;
      count_q    <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_i;
      slot_q <= slot_i;
      null_q <= null_i;
    end
  end

  // An allocate needs the link of the current head; everything else reads the named slot.
  assign mem_re_o    = accept;
  assign mem_raddr_o = (op_i == OP_ALLOC) ? head_q : SlotW'(slot_i);

  assign slot_idx = SlotW'(slot_q);
  assign rd_mark  = mem_rdata_i[SlotW];
  assign rd_link  = mem_rdata_i[SlotW-1:0];

  // Entries at or above the bump counter were never handed out and count as not live.
  assign slot_live = (32'(slot_q) < 32'(SlotCount)) && (32'(slot_q) < 32'(count_q)) && !rd_mark;

  always_comb begin
    head_d        = head_q;
    nonempty_d    = nonempty_q;
    count_d       = count_q;
    mem_we_o      = 1'b0;
    mem_waddr_o   = slot_idx;
    mem_wdata_o   = {1'b1, head_q};
    res_o.valid   = (state_q == ST_EXEC);
    res_o.granted = slot_q;
    res_o.status  = STATUS_OK;
    res_o.live    = 1'b0;
    if (state_q == ST_EXEC) begin
      case (op_q)
        OP_ALLOC: begin
          if (nonempty_q) begin
            res_o.granted = SlotIdxW'(head_q);
            mem_we_o      = 1'b1;
            mem_waddr_o   = head_q;
            mem_wdata_o   = {1'b0, rd_link};
            // The tail of the list links to itself.
            if (rd_link == head_q) begin
              nonempty_d = 1'b0;
            end else begin
              head_d = rd_link;
            end
          end else if (32'(count_q) < 32'(SlotCount)) begin
            res_o.granted = SlotIdxW'(count_q);
            mem_we_o      = 1'b1;
            mem_waddr_o   = count_q[SlotW-1:0];
            mem_wdata_o   = {1'b0, rd_link};
            count_d       = count_q + CntW'(1);
          end else begin
            res_o.granted = '0;
            res_o.status  = STATUS_EXHAUSTED;
          end
        end
        OP_RELEASE: begin
          if (!null_q) begin
            if (!slot_live) begin
              res_o.status = STATUS_BAD_RELEASE;
            end else begin
              mem_we_o    = 1'b1;
              mem_waddr_o = slot_idx;
              mem_wdata_o = {1'b1, (nonempty_q ? head_q : slot_idx)};
              head_d      = slot_idx;
              nonempty_d  = 1'b1;
            end
          end
        end
        OP_QUERY: res_o.live = slot_live;
        default: ;
      endcase
    end
  end

  `FSLF_ASSERT(a_accept_then_busy, clk_i, rst_ni, accept |=> busy_o)
  `FSLF_ASSERT(a_single_exec_cycle, clk_i, rst_ni, busy_o |=> !busy_o)
  `FSLF_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, 32'(count_q) > 32'(SlotCount))
  `FSLF_ASSERT(a_release_fills_list, clk_i, rst_ni, (busy_o && op_q == OP_RELEASE && !null_q && res_o.status == STATUS_OK) |=> nonempty_q)
  `FSLF_ASSERT_NEVER(a_write_when_idle, clk_i, rst_ni, mem_we_o && !busy_o)

endmodule

// ===== design/fixed_slot_free_list_allocator.sv =====
// Top level of the fixed-slot free list allocator: configuration, offset multiply and result register.
`timescale 1ns / 1ps
`include "fixed_slot_free_list_allocator_macros.svh"
// A request is taken at a clock edge where start is high and busy is low. That edge issues one
// read of the slot memory; in the following cycle busy is high while the read data is modified
// and written back and the result is formed, and in the cycle after that the result is shown
// for exactly one cycle with result_valid_o high. The receiver cannot stall it, so it must take
// every strobed result. busy is low again in the cycle the result is shown; a new request is not
// taken while the last is in its read-modify-write of the slot memory. The slot memory needs no
// clearing after reset, and cfg_ready_o is always high.
module fixed_slot_free_list_allocator #(
  parameter int SlotCount = fslf_pkg::SlotCountDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [fslf_pkg::OpW-1:0]       opcode_i,
  input  logic [fslf_pkg::SlotIdxW-1:0]  slot_index_i,
  input  logic                           null_handle_i,
  output logic                           result_valid_o,
  output logic [fslf_pkg::SlotIdxW-1:0]  granted_slot_o,
  output logic [fslf_pkg::OffsetW-1:0]   byte_offset_o,
  output logic [fslf_pkg::StatusW-1:0]   status_o,
  output logic                           is_live_flag_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fslf_pkg::ObjBytesW-1:0] cfg_data_i
);
  import fslf_pkg::*;

  localparam int SlotW = $clog2(SlotCount);
  localparam int ProdW = SlotIdxW + ObjBytesW;

  logic [ObjBytesW-1:0] obj_bytes_q;
  logic                 mem_re;
  logic [SlotW-1:0]     mem_raddr;
  logic [SlotW:0]       mem_rdata;
  logic                 mem_we;
  logic [SlotW-1:0]     mem_waddr;
  logic [SlotW:0]       mem_wdata;
  res_t                 res;
  logic [ProdW-1:0]     product;

  logic                 res_valid_q;
  logic [SlotIdxW-1:0]  granted_q;
  logic [OffsetW-1:0]   offset_q, offset_d;
  logic [StatusW-1:0]   status_q;
  logic                 live_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obj_bytes_q <= ObjBytesReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      obj_bytes_q <= cfg_data_i;
    end
  end

  fslf_mem #(
    .Depth(SlotCount),
    .AddrW(SlotW),
    .DataW(SlotW + 1)
  ) u_mem (
    .clk_i  (clk_i),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata)
  );

  fslf_ctrl #(
    .SlotCount(SlotCount)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_o     (busy),
    .op_i       (opcode_i),
    .slot_i     (slot_index_i),
    .null_i     (null_handle_i),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .res_o      (res)
  );

  // The offset wraps to its low bits; an exhausted pool reports a zero offset.
  assign product  = ProdW'(res.granted) * ProdW'(obj_bytes_q);
  assign offset_d = (res.status == STATUS_EXHAUSTED) ? '0 : product[OffsetW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      granted_q <= res.granted;
      offset_q  <= offset_d;
      status_q  <= res.status;
      live_q    <= res.live;
    end
  end

  assign result_valid_o = res_valid_q;
  assign granted_slot_o = granted_q;
  assign byte_offset_o  = offset_q;
  assign status_o       = status_q;
  assign is_live_flag_o = live_q;

  `FSLF_ASSERT(a_result_follows_exec, clk_i, rst_ni, result_valid_o |-> $past(busy))
  `FSLF_ASSERT(a_exhausted_is_zero, clk_i, rst_ni, (result_valid_o && status_o == STATUS_EXHAUSTED) |-> (byte_offset_o == '0 && granted_slot_o == '0))
  `FSLF_ASSERT_NEVER(a_live_with_error, clk_i, rst_ni, result_valid_o && is_live_flag_o && status_o != STATUS_OK)

endmodule
